// ----- hdl/tes_pkg.sv -----
package tes_pkg;

    localparam int CHAR_BITS_DEFAULT = 16;
    localparam int CHAR_W = 16;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [CHAR_W-1:0] CH_BEL = 16'h0007;
    localparam logic [CHAR_W-1:0] CH_TAB = 16'h0009;
    localparam logic [CHAR_W-1:0] CH_LF = 16'h000A;
    localparam logic [CHAR_W-1:0] CH_CR = 16'h000D;
    localparam logic [CHAR_W-1:0] CH_ESC = 16'h001B;
    localparam logic [CHAR_W-1:0] CH_LBRACKET = 16'h005B;
    localparam logic [CHAR_W-1:0] CH_BACKSLASH = 16'h005C;
    localparam logic [CHAR_W-1:0] CH_RBRACKET = 16'h005D;
    localparam logic [CHAR_W-1:0] CSI_FINAL_LOW = 16'h0040;
    localparam logic [CHAR_W-1:0] CSI_FINAL_HIGH = 16'h007E;
    localparam logic [CHAR_W-1:0] CONTROL_LIMIT = 16'h0020;

    typedef struct packed {
        logic emit_lf;
        logic emit_char;
        logic [CHAR_W-1:0] ch;
    } t_entry;

endpackage

// ----- hdl/tes_if.sv -----
interface tes_in_if;
    logic valid;
    logic ready;
    logic [tes_pkg::CHAR_W-1:0] in_char;

    modport source (output valid, output in_char, input ready);
    modport sink (input valid, input in_char, output ready);
endinterface

interface tes_out_if;
    logic valid;
    logic ready;
    logic [tes_pkg::CHAR_W-1:0] out_char;
    logic last_of_run;

    modport source (output valid, output out_char, output last_of_run, input ready);
    modport sink (input valid, input out_char, input last_of_run, output ready);
endinterface

// ----- hdl/tes_front.sv -----
module tes_front #(
    parameter int CHAR_BITS = tes_pkg::CHAR_BITS_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [tes_pkg::CHAR_W-1:0]   i_char,
    input  logic                         i_full,
    output logic                         o_ready,
    output logic                         o_push,
    output tes_pkg::t_entry              o_entry
);

    localparam int UNIT_W = (CHAR_BITS < tes_pkg::CHAR_W) ? CHAR_BITS : tes_pkg::CHAR_W;
    localparam logic [tes_pkg::CHAR_W-1:0] UNIT_MASK =
        tes_pkg::CHAR_W'((17'(1) << UNIT_W) - 17'(1));

    localparam logic [2:0] MODE_TEXT = 3'd0;
    localparam logic [2:0] MODE_ESC = 3'd1;
    localparam logic [2:0] MODE_CSI = 3'd2;
    localparam logic [2:0] MODE_OSC = 3'd3;
    localparam logic [2:0] MODE_OSC_ESC = 3'd4;
    localparam logic [2:0] MODE_CR = 3'd5;

    logic [2:0] r_mode;
    logic [2:0] n_mode;
    logic [tes_pkg::CHAR_W-1:0] w_c;
    logic w_accept;
    logic w_text;
    logic w_emit_lf;
    logic w_emit_char;

    assign w_c = i_char & UNIT_MASK;
    assign o_ready = !i_full;
    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_mode = r_mode;
        w_text = 1'b0;
        w_emit_lf = 1'b0;
        w_emit_char = 1'b0;
        unique case (r_mode)
            MODE_ESC: begin
                if (w_c == tes_pkg::CH_LBRACKET) begin
                    n_mode = MODE_CSI;
                end else if (w_c == tes_pkg::CH_RBRACKET) begin
                    n_mode = MODE_OSC;
                end else begin
                    n_mode = MODE_TEXT;
                end
            end
            MODE_CSI: begin
                if (w_c >= tes_pkg::CSI_FINAL_LOW && w_c <= tes_pkg::CSI_FINAL_HIGH) begin
                    n_mode = MODE_TEXT;
                end
            end
            MODE_OSC: begin
                if (w_c == tes_pkg::CH_BEL) begin
                    n_mode = MODE_TEXT;
                end else if (w_c == tes_pkg::CH_ESC) begin
                    n_mode = MODE_OSC_ESC;
                end
            end
            MODE_OSC_ESC: begin
                if (w_c == tes_pkg::CH_BACKSLASH || w_c == tes_pkg::CH_BEL) begin
                    n_mode = MODE_TEXT;
                end else if (w_c == tes_pkg::CH_ESC) begin
                    n_mode = MODE_OSC_ESC;
                end else begin
                    n_mode = MODE_OSC;
                end
            end
            MODE_CR: begin
                w_emit_lf = (w_c != tes_pkg::CH_LF);
                w_text = 1'b1;
            end
            default: begin
                w_text = 1'b1;
            end
        endcase
        if (w_text) begin
            if (w_c == tes_pkg::CH_ESC) begin
                n_mode = MODE_ESC;
            end else if (w_c == tes_pkg::CH_CR) begin
                n_mode = MODE_CR;
            end else if (w_c < tes_pkg::CONTROL_LIMIT && w_c != tes_pkg::CH_LF
                         && w_c != tes_pkg::CH_TAB) begin
                n_mode = MODE_TEXT;
            end else begin
                n_mode = MODE_TEXT;
                w_emit_char = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_TEXT;
        end else if (w_accept) begin
            r_mode <= n_mode;
        end
    end

    assign o_push = w_accept && (w_emit_lf || w_emit_char);
    assign o_entry.emit_lf = w_emit_lf;
    assign o_entry.emit_char = w_emit_char;
    assign o_entry.ch = w_c;

endmodule

// ----- hdl/tes_queue.sv -----
module tes_queue #(
    parameter int DEPTH = tes_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tes_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output tes_pkg::t_entry o_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    tes_pkg::t_entry r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic w_push;
    logic w_pop;

    assign o_full = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign w_push = i_push && !o_full;
    assign w_pop = i_pop && o_valid;
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ----- hdl/tes_back.sv -----
module tes_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  tes_pkg::t_entry            i_entry,
    input  logic                       i_ready,
    output logic                       o_pop,
    output logic                       o_valid,
    output logic [tes_pkg::CHAR_W-1:0] o_char,
    output logic                       o_last
);

    logic r_lf_done;
    logic w_lf_now;
    logic w_fire;

    assign w_lf_now = i_entry.emit_lf && !r_lf_done;
    assign o_valid = i_valid;
    assign o_char = w_lf_now ? tes_pkg::CH_LF : i_entry.ch;
    assign o_last = !(w_lf_now && i_entry.emit_char);
    assign w_fire = i_valid && i_ready;
    assign o_pop = w_fire && o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lf_done <= 1'b0;
        end else if (w_fire) begin
            r_lf_done <= !o_last;
        end
    end

endmodule

// ----- hdl/terminal_escape_stripper.sv -----
// A unit that yields text enters the queue when accepted; the output is the queue head.
// One unit per cycle is taken while the queue is not full; a CR replaced before a kept
// unit gives an LF and that unit; the front mode register and two-entry queue do this.
// Reset is synchronous and active low; it returns to plain text mode and empties the queue.
// A partial escape sequence or a held CR is discarded by reset.
module terminal_escape_stripper #(
    parameter int CHAR_BITS = tes_pkg::CHAR_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = tes_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tes_in_if.sink     i_in,
    tes_out_if.source  o_out
);

    logic w_full;
    logic w_push;
    logic w_pop;
    logic w_q_valid;
    tes_pkg::t_entry w_push_entry;
    tes_pkg::t_entry w_head_entry;

    tes_front #(
        .CHAR_BITS(CHAR_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_char  (i_in.in_char),
        .i_full  (w_full),
        .o_ready (i_in.ready),
        .o_push  (w_push),
        .o_entry (w_push_entry)
    );

    tes_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_entry (w_head_entry)
    );

    tes_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_entry (w_head_entry),
        .i_ready (o_out.ready),
        .o_pop   (w_pop),
        .o_valid (o_out.valid),
        .o_char  (o_out.out_char),
        .o_last  (o_out.last_of_run)
    );

endmodule

// ----- sim/stripped_text_checker.sv -----
module stripped_text_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    tes_in_if    i_in_mon,
    tes_out_if   i_out_mon,
    output int   o_fail_count,
    output int   o_waiting,
    output int   o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        M_TEXT,
        M_ESC,
        M_CSI,
        M_OSC,
        M_OSC_ESC,
        M_CR
    } t_mode;

    typedef struct packed {
        logic [tes_pkg::CHAR_W-1:0] ch;
        logic                       last;
    } t_text;

    t_mode filter_mode;
    t_text expected_text[$];
    int    fails = 0;
    int    checked = 0;

    function automatic logic keeps_unit(input logic [tes_pkg::CHAR_W-1:0] c);
        return (c >= tes_pkg::CONTROL_LIMIT) || (c == tes_pkg::CH_LF)
               || (c == tes_pkg::CH_TAB);
    endfunction

    function automatic t_mode plain_mode(input logic [tes_pkg::CHAR_W-1:0] c);
        if (c == tes_pkg::CH_ESC) begin
            return M_ESC;
        end
        if (c == tes_pkg::CH_CR) begin
            return M_CR;
        end
        return M_TEXT;
    endfunction

    always @(posedge i_clk) begin : watch
        logic [tes_pkg::CHAR_W-1:0] c;
        logic [tes_pkg::CHAR_W-1:0] made [2];
        int                         n;
        t_text                      got;
        t_text                      want;
        if (!i_rst_n) begin
            filter_mode = M_TEXT;
            expected_text.delete();
        end else begin
            if (i_in_mon.valid && i_in_mon.ready) begin
                c = i_in_mon.in_char;
                n = 0;
                case (filter_mode)
                    M_ESC: begin
                        if (c == tes_pkg::CH_LBRACKET) begin
                            filter_mode = M_CSI;
                        end else if (c == tes_pkg::CH_RBRACKET) begin
                            filter_mode = M_OSC;
                        end else begin
                            filter_mode = M_TEXT;
                        end
                    end
                    M_CSI: begin
                        if (c >= tes_pkg::CSI_FINAL_LOW && c <= tes_pkg::CSI_FINAL_HIGH) begin
                            filter_mode = M_TEXT;
                        end
                    end
                    M_OSC: begin
                        if (c == tes_pkg::CH_BEL) begin
                            filter_mode = M_TEXT;
                        end else if (c == tes_pkg::CH_ESC) begin
                            filter_mode = M_OSC_ESC;
                        end
                    end
                    M_OSC_ESC: begin
                        if (c == tes_pkg::CH_BACKSLASH || c == tes_pkg::CH_BEL) begin
                            filter_mode = M_TEXT;
                        end else if (c == tes_pkg::CH_ESC) begin
                            filter_mode = M_OSC_ESC;
                        end else begin
                            filter_mode = M_OSC;
                        end
                    end
                    M_CR: begin
                        if (c != tes_pkg::CH_LF) begin
                            made[n] = tes_pkg::CH_LF;
                            n++;
                        end
                        if (keeps_unit(c)) begin
                            made[n] = c;
                            n++;
                        end
                        filter_mode = plain_mode(c);
                    end
                    default: begin
                        if (keeps_unit(c)) begin
                            made[n] = c;
                            n++;
                        end
                        filter_mode = plain_mode(c);
                    end
                endcase
                for (int k = 0; k < n; k++) begin
                    expected_text.push_back('{ch: made[k], last: (k == n - 1)});
                end
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                got = '{ch: i_out_mon.out_char, last: i_out_mon.last_of_run};
                if (expected_text.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result out_char=%h last_of_run=%b",
                             $realtime, got.ch, got.last);
                end else begin
                    want = expected_text.pop_front();
                    checked++;
                    if (got.ch !== want.ch) begin
                        fails++;
                        $display("%0t: out_char expected %h, got %h",
                                 $realtime, want.ch, got.ch);
                    end
                    if (got.last !== want.last) begin
                        fails++;
                        $display("%0t: last_of_run expected %b, got %b (out_char %h)",
                                 $realtime, want.last, got.last, got.ch);
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_waiting <= expected_text.size();
        o_checked <= checked;
    end

endmodule

// ----- sim/tb_terminal_escape_stripper.sv -----
module tb_terminal_escape_stripper;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_UNITS = 1750;
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_LIMIT = 3000;
    localparam int OPENING_UNITS = 24;

    typedef logic [tes_pkg::CHAR_W-1:0] t_unit;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tes_in_if  in_if ();
    tes_out_if out_if ();

    terminal_escape_stripper uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    int fail_count;
    int waiting;
    int checked;

    stripped_text_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_if),
        .i_out_mon    (out_if),
        .o_fail_count (fail_count),
        .o_waiting    (waiting),
        .o_checked    (checked)
    );

    int units_sent = 0;
    int burst_left = 0;
    int csi_sent = 0;
    int osc_sent = 0;
    int idle_cycles = 0;
    bit hold_request = 1'b0;

    t_unit opening [OPENING_UNITS] = '{
        16'h0041, 16'h0000, 16'hFFFF, tes_pkg::CH_TAB, tes_pkg::CH_BEL,
        tes_pkg::CH_CR, tes_pkg::CH_LF,
        tes_pkg::CH_CR, tes_pkg::CH_CR, 16'h0078,
        tes_pkg::CH_ESC, tes_pkg::CH_LBRACKET, tes_pkg::CH_ESC, tes_pkg::CSI_FINAL_HIGH,
        tes_pkg::CH_ESC, tes_pkg::CH_RBRACKET, tes_pkg::CH_ESC, 16'h0062,
        tes_pkg::CH_ESC, tes_pkg::CH_ESC, tes_pkg::CH_BEL,
        tes_pkg::CH_ESC, tes_pkg::CH_ESC, 16'h0071
    };

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $realtime, IDLE_LIMIT);
                $display("** terminal_escape_stripper: FAILED **");
                $finish;
            end
        end
    end

    initial begin : receiver
        int style;
        int span;
        int tick;
        bit hold_done;
        style = 0;
        span = 0;
        tick = 0;
        hold_done = 1'b0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (hold_request && !hold_done) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                if (span == 0) begin
                    style = $urandom_range(0, 3);
                    span = $urandom_range(10, 120);
                end
                span--;
                case (style)
                    0: out_if.ready <= 1'b1;
                    1: out_if.ready <= ($urandom_range(0, 3) != 0);
                    2: out_if.ready <= ((tick % 5) != 0);
                    default: out_if.ready <= ($urandom_range(0, 1) != 0);
                endcase
            end
        end
    end

    task automatic push_unit(input t_unit c);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 12);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 10);
        end
        in_if.valid <= 1'b1;
        in_if.in_char <= c;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        burst_left--;
        units_sent++;
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (waiting != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic t_unit random_text();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 15) begin
            return t_unit'($urandom_range(16'h0020, 16'h007E));
        end
        if (pick < 18) begin
            return t_unit'($urandom);
        end
        return (pick == 18) ? tes_pkg::CH_LF : tes_pkg::CH_TAB;
    endfunction

    task automatic random_chunk();
        int kind;
        kind = $urandom_range(0, 9);
        case (kind) inside
            [0:3]: begin
                repeat ($urandom_range(1, 8)) push_unit(random_text());
            end
            4: begin
                push_unit(tes_pkg::CH_ESC);
                push_unit(tes_pkg::CH_LBRACKET);
                repeat ($urandom_range(0, 4)) begin
                    push_unit(t_unit'($urandom_range(16'h0030, 16'h003F)));
                end
                if ($urandom_range(0, 3) == 0) begin
                    push_unit(t_unit'($urandom_range(16'h0020, 16'h002F)));
                end
                push_unit(t_unit'($urandom_range(tes_pkg::CSI_FINAL_LOW,
                                                 tes_pkg::CSI_FINAL_HIGH)));
                csi_sent++;
            end
            5: begin
                push_unit(tes_pkg::CH_ESC);
                push_unit(tes_pkg::CH_RBRACKET);
                repeat ($urandom_range(0, 6)) begin
                    if ($urandom_range(0, 5) == 0) begin
                        push_unit(tes_pkg::CH_ESC);
                    end
                    push_unit(random_text());
                end
                if ($urandom_range(0, 1) == 0) begin
                    push_unit(tes_pkg::CH_BEL);
                end else begin
                    push_unit(tes_pkg::CH_ESC);
                    push_unit(tes_pkg::CH_BACKSLASH);
                end
                osc_sent++;
            end
            6: begin
                push_unit(tes_pkg::CH_CR);
                case ($urandom_range(0, 2))
                    0: push_unit(tes_pkg::CH_LF);
                    1: push_unit(tes_pkg::CH_CR);
                    default: push_unit(random_text());
                endcase
            end
            7: begin
                push_unit(tes_pkg::CH_ESC);
                push_unit(t_unit'($urandom));
            end
            8: begin
                if ($urandom_range(0, 1) == 0) begin
                    push_unit(t_unit'($urandom_range(0, tes_pkg::CONTROL_LIMIT - 1)));
                end else begin
                    push_unit(t_unit'($urandom));
                end
            end
            default: begin
                push_unit(tes_pkg::CH_ESC);
                push_unit(($urandom_range(0, 3) == 0) ? tes_pkg::CH_RBRACKET
                                                      : tes_pkg::CH_LBRACKET);
                repeat ($urandom_range(1, 4)) push_unit(t_unit'($urandom));
            end
        endcase
    endtask

    initial begin : stimulus
        bit hold_started;
        bit pause_taken;
        hold_started = 1'b0;
        pause_taken = 1'b0;
        i_rst_n <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.in_char <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (opening[k]) begin
            push_unit(opening[k]);
        end
        drain();
        while (units_sent < OPENING_UNITS + RANDOM_UNITS) begin
            if (!hold_started && units_sent > 600) begin
                hold_request = 1'b1;
                hold_started = 1'b1;
            end
            if (!pause_taken && units_sent > 1200) begin
                drain();
                pause_taken = 1'b1;
            end
            random_chunk();
        end
        drain();
        repeat (8) @(posedge i_clk);
        $display("Fed %0d code units, among them %0d CSI and %0d OSC sequences,",
                 units_sent, csi_sent, osc_sent);
        $display("and compared %0d stripped output units.", checked);
        if (fail_count == 0) begin
            $display("** terminal_escape_stripper: PASSED **");
        end else begin
            $display("** terminal_escape_stripper: FAILED **");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/tes_pkg.sv
hdl/tes_if.sv
hdl/tes_front.sv
hdl/tes_queue.sv
hdl/tes_back.sv
hdl/terminal_escape_stripper.sv
sim/stripped_text_checker.sv
sim/tb_terminal_escape_stripper.sv
